// ===== sv/edid_base_block_parser_core_assert.svh =====
// Assertion macros for the EDID base block parser core.
// Expects clk and arst_n in the scope that uses them; no other dependencies.
`ifndef EDID_BASE_BLOCK_PARSER_CORE_ASSERT_SVH
`define EDID_BASE_BLOCK_PARSER_CORE_ASSERT_SVH

`define EBBP_ASSERT_SAME(label, cond, consq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (consq)) \
		else $error(msg);

`define EBBP_ASSERT_NEXT(label, cond, consq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (consq)) \
		else $error(msg);

`endif

// ===== sv/ebbp_pkg.sv =====
// Shared types and constants for the EDID base block parser core.
// No dependencies; used by ebbp_decode and the top level.
package ebbp_pkg;

	typedef enum logic [1:0] {
		KIND_TIMING  = 2'd0,
		KIND_DISPLAY = 2'd1,
		KIND_UNKNOWN = 2'd2,
		KIND_SUMMARY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_VALID        = 2'd0,
		STATUS_CHECKSUM_BAD = 2'd1,
		STATUS_HEADER_BAD   = 2'd2,
		STATUS_VERSION_BAD  = 2'd3
	} status_t;

	localparam logic [6:0] BLOCK_LAST   = 7'd127;
	localparam logic [6:0] DESC_START   = 7'h36;
	localparam logic [6:0] VERSION_POS  = 7'h12;
	localparam logic [6:0] REVISION_POS = 7'h13;
	localparam int         DESC_SIZE    = 18;
	localparam logic [4:0] DESC_LAST    = 5'(DESC_SIZE - 1);
	localparam logic [7:0] VERSION_OK   = 8'd1;
	localparam logic [7:0] REVISION_MAX = 8'd4;

	typedef logic [DESC_SIZE-2:0][7:0] desc_head_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] dot_clock;
		logic [11:0] h_visible;
		logic [11:0] h_blank;
		logic [11:0] v_visible;
		logic [11:0] v_blank;
		logic [9:0]  h_front_porch;
		logic [9:0]  h_pulse;
		logic [5:0]  v_front_porch;
		logic [5:0]  v_pulse;
		logic [7:0]  flag_or_tag;
		status_t     status;
	} result_t;

	function automatic logic [7:0] header_byte(input logic [2:0] idx);
		return (idx == 3'd0 || idx == 3'd7) ? 8'h00 : 8'hff;
	endfunction

endpackage

// ===== sv/ebbp_decode.sv =====
// Decodes one 18-byte descriptor into a timing, display or unknown descriptor result.
// Depends on ebbp_pkg.
module ebbp_decode import ebbp_pkg::*; (
	input  desc_head_t  head,
	input  logic [7:0]  last_byte,
	output result_t     result
);

	always_comb begin
		result = '0;
		if (head[0] != 8'd0 || head[1] != 8'd0) begin
			result.kind          = KIND_TIMING;
			result.dot_clock     = {head[1], head[0]};
			result.h_visible     = {head[4][7:4], head[2]};
			result.h_blank       = {head[4][3:0], head[3]};
			result.v_visible     = {head[7][7:4], head[5]};
			result.v_blank       = {head[7][3:0], head[6]};
			result.h_front_porch = {head[11][7:6], head[8]};
			result.h_pulse       = {head[11][5:4], head[9]};
			result.v_front_porch = {head[11][3:2], head[10][7:4]};
			result.v_pulse       = {head[11][1:0], head[10][3:0]};
			result.flag_or_tag   = last_byte;
		end else if (head[2] != 8'd0) begin
			result.kind = KIND_UNKNOWN;
		end else begin
			result.kind        = KIND_DISPLAY;
			result.flag_or_tag = head[3];
		end
	end

endmodule

// ===== sv/edid_base_block_parser_core.sv =====
// A byte that causes a result passes through the input register, and the result is then held in the result register.
// Throughput: one byte per cycle; the input register and the result register let a new byte
// enter while a result waits, and only a stalled, full result register holds the input.
// Reset (arst_n low): byte position, checksum, header flag, version and revision clear at once;
// the descriptor store is not reset. The state also clears after byte 127 of every block.
// Depends on ebbp_pkg, ebbp_decode and edid_base_block_parser_core_assert.svh.
`include "edid_base_block_parser_core_assert.svh"

module edid_base_block_parser_core import ebbp_pkg::*; #(
	parameter int DESCRIPTOR_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] dot_clock,
	output logic [11:0] h_visible,
	output logic [11:0] h_blank,
	output logic [11:0] v_visible,
	output logic [11:0] v_blank,
	output logic [9:0]  h_front_porch,
	output logic [9:0]  h_pulse,
	output logic [5:0]  v_front_porch,
	output logic [5:0]  v_pulse,
	output logic [7:0]  flag_or_tag,
	output logic [1:0]  status
);

	localparam logic [6:0] DESC_END = 7'(DESC_START + DESC_SIZE * DESCRIPTOR_COUNT);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic [6:0]  pos_q;
	logic [7:0]  sum_q;
	logic        hdr_match_q;
	logic [7:0]  version_q;
	logic [7:0]  revision_q;
	logic [4:0]  desc_off_q;
	logic [7:0]  desc_q [DESC_SIZE-1];

	logic        step;
	logic        in_desc;
	logic        desc_done;
	logic [7:0]  sum_next;
	logic        hdr_ok;
	desc_head_t  head;
	result_t     desc_result;
	result_t     summary;
	result_t     out_q;
	logic        out_valid_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	assign in_desc   = (pos_q >= DESC_START) && (pos_q < DESC_END);
	assign desc_done = in_desc && (desc_off_q == DESC_LAST);
	assign sum_next  = sum_q + byte_s1;
	assign hdr_ok    = (pos_q[6:3] != 4'd0) || (byte_s1 == header_byte(pos_q[2:0]));

	always_comb begin
		for (int i = 0; i < DESC_SIZE - 1; i++) begin
			head[i] = desc_q[i];
		end
	end

	ebbp_decode u_decode (
		.head      (head),
		.last_byte (byte_s1),
		.result    (desc_result)
	);

	always_comb begin
		summary      = '0;
		summary.kind = KIND_SUMMARY;
		if (sum_next != 8'd0) begin
			summary.status = STATUS_CHECKSUM_BAD;
		end else if (!hdr_match_q) begin
			summary.status = STATUS_HEADER_BAD;
		end else if (version_q != VERSION_OK || revision_q > REVISION_MAX) begin
			summary.status = STATUS_VERSION_BAD;
		end else begin
			summary.status = STATUS_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			hdr_match_q <= 1'b1;
			version_q   <= '0;
			revision_q  <= '0;
			desc_off_q  <= '0;
		end else if (step) begin
			if (pos_q == BLOCK_LAST) begin
				pos_q       <= '0;
				sum_q       <= '0;
				hdr_match_q <= 1'b1;
				version_q   <= '0;
				revision_q  <= '0;
				desc_off_q  <= '0;
			end else begin
				pos_q       <= pos_q + 7'd1;
				sum_q       <= sum_next;
				hdr_match_q <= hdr_match_q && hdr_ok;
				if (pos_q == VERSION_POS) begin
					version_q <= byte_s1;
				end
				if (pos_q == REVISION_POS) begin
					revision_q <= byte_s1;
				end
				if (in_desc) begin
					desc_off_q <= desc_done ? 5'd0 : desc_off_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_desc && !desc_done) begin
			desc_q[desc_off_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && (desc_done || pos_q == BLOCK_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (step && pos_q == BLOCK_LAST) begin
			out_q <= summary;
		end else if (step && desc_done) begin
			out_q <= desc_result;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign dot_clock     = out_q.dot_clock;
	assign h_visible     = out_q.h_visible;
	assign h_blank       = out_q.h_blank;
	assign v_visible     = out_q.v_visible;
	assign v_blank       = out_q.v_blank;
	assign h_front_porch = out_q.h_front_porch;
	assign h_pulse       = out_q.h_pulse;
	assign v_front_porch = out_q.v_front_porch;
	assign v_pulse       = out_q.v_pulse;
	assign flag_or_tag   = out_q.flag_or_tag;
	assign status        = out_q.status;

	`EBBP_ASSERT_NEXT(a_summary_at_end, step && pos_q == BLOCK_LAST,
		out_valid_q && out_q.kind == KIND_SUMMARY, "missing block summary after last byte")
	`EBBP_ASSERT_NEXT(a_restart_clear, step && pos_q == BLOCK_LAST,
		pos_q == 7'd0 && sum_q == 8'd0 && hdr_match_q, "state not cleared after last byte")
	`EBBP_ASSERT_SAME(a_offset_idle, pos_q < DESC_START,
		desc_off_q == 5'd0, "descriptor offset moved before first descriptor")

endmodule
